@@ hdl/lavm_pkg.sv @@
package lavm_pkg;

    // Field widths
    localparam int CW        = 32;   // coordinate, Q16.16
    localparam int UW        = 18;   // unit vector component, Q1.16
    localparam int NW        = 52;   // signed width into the normalizer
    localparam int UNIT_FRAC = 16;
    localparam int UNIT_ONE  = 1 << UNIT_FRAC;

    // Rounded value of an NW-bit product sum
    localparam int RND_W = NW - UNIT_FRAC + 1;

    // Product widths
    localparam int PCW = UW + CW;    // unit times coordinate
    localparam int PUW = 2 * UW;     // unit times unit

    // Normalizer depth
    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = UNIT_FRAC + 1;
    localparam int NORM_LAT  = 5 + SQ_STEPS + 1 + DIV_STEPS + 1;

    typedef logic signed [CW-1:0]    coord_t;
    typedef logic signed [UW-1:0]    unit_t;
    typedef logic signed [NW-1:0]    nwide_t;
    typedef logic signed [RND_W-1:0] rnd_t;
    typedef logic signed [PCW-1:0]   pcu_t;
    typedef logic signed [PUW-1:0]   puu_t;

    localparam rnd_t CMAX = {{(RND_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam rnd_t CMIN = {{(RND_W-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam rnd_t UMAX = RND_W'(UNIT_ONE);
    localparam rnd_t UMIN = -RND_W'(UNIT_ONE);

    // Shift right by UNIT_FRAC, round half away from zero
    function automatic rnd_t round_unit(input nwide_t x);
        logic [NW-1:0] m;
        logic [NW-1:0] half;
        logic [NW-1:0] sum;
        rnd_t          r;
        m    = x[NW-1] ? NW'(-x) : NW'(x);
        half = NW'(1) << (UNIT_FRAC - 1);
        sum  = m + half;
        r    = $signed({1'b0, sum[NW-1:UNIT_FRAC]});
        return x[NW-1] ? -r : r;
    endfunction

    // Saturate to the coordinate range
    function automatic coord_t sat_coord(input rnd_t x);
        coord_t r;
        if (x > CMAX)
            r = CMAX[CW-1:0];
        else if (x < CMIN)
            r = CMIN[CW-1:0];
        else
            r = x[CW-1:0];
        return r;
    endfunction

    // Clamp to [-1, 1] in Q1.16
    function automatic unit_t clamp_unit(input rnd_t x);
        unit_t r;
        if (x > UMAX)
            r = UMAX[UW-1:0];
        else if (x < UMIN)
            r = UMIN[UW-1:0];
        else
            r = x[UW-1:0];
        return r;
    endfunction

endpackage

@@ hdl/lavm_if.sv @@
interface lavm_cam_if;
    logic            valid;
    logic            ready;
    lavm_pkg::coord_t eye_x;
    lavm_pkg::coord_t eye_y;
    lavm_pkg::coord_t eye_z;
    lavm_pkg::coord_t target_x;
    lavm_pkg::coord_t target_y;
    lavm_pkg::coord_t target_z;
    lavm_pkg::coord_t upref_x;
    lavm_pkg::coord_t upref_y;
    lavm_pkg::coord_t upref_z;

    modport source (
        output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               upref_x, upref_y, upref_z,
        input  ready
    );
    modport sink (
        input  valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
               upref_x, upref_y, upref_z,
        output ready
    );
endinterface

interface lavm_view_if;
    logic            valid;
    logic            ready;
    lavm_pkg::unit_t  side_x;
    lavm_pkg::unit_t  side_y;
    lavm_pkg::unit_t  side_z;
    lavm_pkg::unit_t  vert_x;
    lavm_pkg::unit_t  vert_y;
    lavm_pkg::unit_t  vert_z;
    lavm_pkg::unit_t  back_x;
    lavm_pkg::unit_t  back_y;
    lavm_pkg::unit_t  back_z;
    lavm_pkg::coord_t shift_x;
    lavm_pkg::coord_t shift_y;
    lavm_pkg::coord_t shift_z;

    modport source (
        output valid, side_x, side_y, side_z, vert_x, vert_y, vert_z,
               back_x, back_y, back_z, shift_x, shift_y, shift_z,
        input  ready
    );
    modport sink (
        input  valid, side_x, side_y, side_z, vert_x, vert_y, vert_z,
               back_x, back_y, back_z, shift_x, shift_y, shift_z,
        output ready
    );
endinterface

@@ hdl/look_at_view_matrix_core.sv @@
// Channel  Role    Payload
// cam      sink    eye, target, upref: nine signed Q16.16 coordinates
// view     source  side, vert, back (Q1.16), shift (Q16.16, saturated)
//
// One camera set-up is taken every cycle while the output is not stalled.
// Each of the two normalizers holds 55 stages: prescale, squares, a
// 31-stage square root and a 17-stage divider, one result bit per stage.
// Reset clears the valid bits only.
// A stalled output holds the whole pipeline in place; nothing is lost.
module look_at_view_matrix_core (
    input logic        clk,
    input logic        rst_n,
    lavm_cam_if.sink   cam,
    lavm_view_if.source view
);
    import lavm_pkg::*;

    logic en;

    // Advance the pipeline unless a result waits
    assign en        = !view.valid || view.ready;
    assign cam.ready = en;

    // Stage 0: capture transfer, form target minus eye
    logic   vld0_reg;
    coord_t eye0_reg [3];
    coord_t upr0_reg [3];
    nwide_t d0_reg   [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld0_reg <= 1'b0;
        else if (en)
            vld0_reg <= cam.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eye0_reg[0] <= cam.eye_x;
            eye0_reg[1] <= cam.eye_y;
            eye0_reg[2] <= cam.eye_z;
            upr0_reg[0] <= cam.upref_x;
            upr0_reg[1] <= cam.upref_y;
            upr0_reg[2] <= cam.upref_z;
            d0_reg[0]   <= nwide_t'(cam.target_x) - nwide_t'(cam.eye_x);
            d0_reg[1]   <= nwide_t'(cam.target_y) - nwide_t'(cam.eye_y);
            d0_reg[2]   <= nwide_t'(cam.target_z) - nwide_t'(cam.eye_z);
        end
    end

    // Forward vector
    logic  vld_fa;
    logic  zero_fa;
    unit_t f_a [3];

    lavm_norm u_norm_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (vld0_reg),
        .vin      (d0_reg),
        .vld_out  (vld_fa),
        .zero_out (zero_fa),
        .uout     (f_a)
    );

    // Delay eye and upref alongside the forward normalizer
    coord_t eyea_reg [NORM_LAT][3];
    coord_t upra_reg [NORM_LAT][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eyea_reg[0] <= eye0_reg;
            upra_reg[0] <= upr0_reg;
            for (int k = 1; k < NORM_LAT; k++)
            begin
                eyea_reg[k] <= eyea_reg[k-1];
                upra_reg[k] <= upra_reg[k-1];
            end
        end
    end

    // Stage 1: products of forward cross upref
    logic   vld1_reg;
    logic   z1_reg;
    unit_t  f1_reg   [3];
    coord_t eye1_reg [3];
    pcu_t   pc1_reg  [6];
    coord_t upa      [3];

    assign upa = upra_reg[NORM_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else if (en)
            vld1_reg <= vld_fa;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z1_reg     <= zero_fa;
            f1_reg     <= f_a;
            eye1_reg   <= eyea_reg[NORM_LAT-1];
            pc1_reg[0] <= f_a[1] * upa[2];
            pc1_reg[1] <= f_a[2] * upa[1];
            pc1_reg[2] <= f_a[2] * upa[0];
            pc1_reg[3] <= f_a[0] * upa[2];
            pc1_reg[4] <= f_a[0] * upa[1];
            pc1_reg[5] <= f_a[1] * upa[0];
        end
    end

    // Stage 2: cross product differences
    logic   vld2_reg;
    logic   z2_reg;
    unit_t  f2_reg   [3];
    coord_t eye2_reg [3];
    nwide_t c2_reg   [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld2_reg <= 1'b0;
        else if (en)
            vld2_reg <= vld1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z2_reg    <= z1_reg;
            f2_reg    <= f1_reg;
            eye2_reg  <= eye1_reg;
            c2_reg[0] <= nwide_t'(pc1_reg[0]) - nwide_t'(pc1_reg[1]);
            c2_reg[1] <= nwide_t'(pc1_reg[2]) - nwide_t'(pc1_reg[3]);
            c2_reg[2] <= nwide_t'(pc1_reg[4]) - nwide_t'(pc1_reg[5]);
        end
    end

    // Right vector
    logic  vld_rb;
    logic  zero_rb;
    unit_t r_b [3];

    lavm_norm u_norm_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (vld2_reg),
        .vin      (c2_reg),
        .vld_out  (vld_rb),
        .zero_out (zero_rb),
        .uout     (r_b)
    );

    // Delay forward, eye and the zero flag alongside the side normalizer
    unit_t                fb_reg   [NORM_LAT][3];
    coord_t               eyeb_reg [NORM_LAT][3];
    logic [NORM_LAT-1:0]  zb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fb_reg[0]   <= f2_reg;
            eyeb_reg[0] <= eye2_reg;
            zb_reg      <= {zb_reg[NORM_LAT-2:0], z2_reg};
            for (int k = 1; k < NORM_LAT; k++)
            begin
                fb_reg[k]   <= fb_reg[k-1];
                eyeb_reg[k] <= eyeb_reg[k-1];
            end
        end
    end

    // Stage 3: products for true up and the side and forward dots
    logic   vld3_reg;
    logic   z3_reg;
    unit_t  r3_reg   [3];
    unit_t  f3_reg   [3];
    coord_t eye3_reg [3];
    puu_t   rf3_reg  [6];
    pcu_t   re3_reg  [3];
    pcu_t   fe3_reg  [3];
    unit_t  fb       [3];
    coord_t eb       [3];

    assign fb = fb_reg[NORM_LAT-1];
    assign eb = eyeb_reg[NORM_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld3_reg <= 1'b0;
        else if (en)
            vld3_reg <= vld_rb;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z3_reg     <= zero_rb || zb_reg[NORM_LAT-1];
            r3_reg     <= r_b;
            f3_reg     <= fb;
            eye3_reg   <= eb;
            rf3_reg[0] <= r_b[1] * fb[2];
            rf3_reg[1] <= r_b[2] * fb[1];
            rf3_reg[2] <= r_b[2] * fb[0];
            rf3_reg[3] <= r_b[0] * fb[2];
            rf3_reg[4] <= r_b[0] * fb[1];
            rf3_reg[5] <= r_b[1] * fb[0];
            for (int i = 0; i < 3; i++)
            begin
                re3_reg[i] <= r_b[i] * eb[i];
                fe3_reg[i] <= fb[i] * eb[i];
            end
        end
    end

    // Stage 4: round and clamp true up, finish side and forward shifts
    logic   vld4_reg;
    logic   z4_reg;
    unit_t  r4_reg   [3];
    unit_t  f4_reg   [3];
    unit_t  u4_reg   [3];
    coord_t eye4_reg [3];
    coord_t t0_4_reg;
    coord_t t2_4_reg;
    nwide_t raw      [3];
    nwide_t dot_r;
    nwide_t dot_f;

    always_comb
    begin
        raw[0] = nwide_t'(rf3_reg[0]) - nwide_t'(rf3_reg[1]);
        raw[1] = nwide_t'(rf3_reg[2]) - nwide_t'(rf3_reg[3]);
        raw[2] = nwide_t'(rf3_reg[4]) - nwide_t'(rf3_reg[5]);
        dot_r  = nwide_t'(re3_reg[0]) + nwide_t'(re3_reg[1]) + nwide_t'(re3_reg[2]);
        dot_f  = nwide_t'(fe3_reg[0]) + nwide_t'(fe3_reg[1]) + nwide_t'(fe3_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld4_reg <= 1'b0;
        else if (en)
            vld4_reg <= vld3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z4_reg   <= z3_reg;
            r4_reg   <= r3_reg;
            f4_reg   <= f3_reg;
            eye4_reg <= eye3_reg;
            for (int i = 0; i < 3; i++)
                u4_reg[i] <= clamp_unit(round_unit(raw[i]));
            t0_4_reg <= sat_coord(-round_unit(dot_r));
            t2_4_reg <= sat_coord(round_unit(dot_f));
        end
    end

    // Stage 5: products of true up and eye
    logic   vld5_reg;
    logic   z5_reg;
    unit_t  r5_reg  [3];
    unit_t  f5_reg  [3];
    unit_t  u5_reg  [3];
    coord_t t0_5_reg;
    coord_t t2_5_reg;
    pcu_t   ue5_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld5_reg <= 1'b0;
        else if (en)
            vld5_reg <= vld4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z5_reg   <= z4_reg;
            r5_reg   <= r4_reg;
            f5_reg   <= f4_reg;
            u5_reg   <= u4_reg;
            t0_5_reg <= t0_4_reg;
            t2_5_reg <= t2_4_reg;
            for (int i = 0; i < 3; i++)
                ue5_reg[i] <= u4_reg[i] * eye4_reg[i];
        end
    end

    // Stage 6: up shift, zero masking, output register
    logic   vo_reg;
    unit_t  side_reg [3];
    unit_t  vert_reg [3];
    unit_t  back_reg [3];
    coord_t shf_reg  [3];
    nwide_t dot_u;
    coord_t t1;

    always_comb
    begin
        dot_u = nwide_t'(ue5_reg[0]) + nwide_t'(ue5_reg[1]) + nwide_t'(ue5_reg[2]);
        t1    = sat_coord(-round_unit(dot_u));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= vld5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                side_reg[i] <= z5_reg ? '0 : r5_reg[i];
                vert_reg[i] <= z5_reg ? '0 : u5_reg[i];
                back_reg[i] <= z5_reg ? '0 : -f5_reg[i];
            end
            shf_reg[0] <= z5_reg ? '0 : t0_5_reg;
            shf_reg[1] <= z5_reg ? '0 : t1;
            shf_reg[2] <= z5_reg ? '0 : t2_5_reg;
        end
    end

    assign view.valid   = vo_reg;
    assign view.side_x  = side_reg[0];
    assign view.side_y  = side_reg[1];
    assign view.side_z  = side_reg[2];
    assign view.vert_x  = vert_reg[0];
    assign view.vert_y  = vert_reg[1];
    assign view.vert_z  = vert_reg[2];
    assign view.back_x  = back_reg[0];
    assign view.back_y  = back_reg[1];
    assign view.back_z  = back_reg[2];
    assign view.shift_x = shf_reg[0];
    assign view.shift_y = shf_reg[1];
    assign view.shift_z = shf_reg[2];

endmodule

@@ hdl/lavm_norm.sv @@
module lavm_norm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld_in,
    input  lavm_pkg::nwide_t vin [3],
    output logic             vld_out,
    output logic             zero_out,
    output lavm_pkg::unit_t  uout [3]
);
    import lavm_pkg::*;

    localparam int MW   = NW - 1;          // magnitude width
    localparam int PW   = $clog2(MW);      // leading-one position
    localparam int NMW  = 30;              // prescaled magnitude
    localparam int SW   = 2 * SQ_STEPS;    // sum of squares
    localparam int RW   = SQ_STEPS + 3;    // root remainder
    localparam int LW   = SQ_STEPS;        // root
    localparam int NUMW = NMW + UNIT_FRAC + 1;
    localparam int DW   = NUMW + 1;
    localparam int QW   = DIV_STEPS;
    localparam logic [PW-1:0] NORM_POS = PW'(NMW - 1);

    typedef struct packed {
        logic [2:0][NMW-1:0] nm;
        logic [2:0]          sgn;
        logic                zero;
    } cp_t;

    typedef struct packed {
        logic [SW-1:0] s;
        logic [RW-1:0] rem;
        logic [LW-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [2:0][DW-1:0] rem;
        logic [2:0][QW-1:0] q;
        logic [LW-1:0]      len;
        logic [2:0]         sgn;
        logic               zero;
    } dv_t;

    // Stage 1: magnitudes and signs
    logic          vld1_reg;
    logic [MW-1:0] mag1_reg [3];
    logic [2:0]    sgn1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else if (en)
            vld1_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= vin[i][NW-1] ? MW'(-vin[i]) : MW'(vin[i]);
                sgn1_reg[i] <= vin[i][NW-1];
            end
        end
    end

    // Stage 2: leading one of the largest magnitude
    logic          vld2_reg;
    logic [MW-1:0] mag2_reg [3];
    logic [2:0]    sgn2_reg;
    logic [PW-1:0] pos2_reg;
    logic          zero2_reg;
    logic [MW-1:0] orv;
    logic [PW-1:0] pos_next;

    always_comb
    begin
        orv      = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        pos_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (orv[i])
                pos_next = PW'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld2_reg <= 1'b0;
        else if (en)
            vld2_reg <= vld1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag2_reg  <= mag1_reg;
            sgn2_reg  <= sgn1_reg;
            pos2_reg  <= pos_next;
            zero2_reg <= (orv == '0);
        end
    end

    // Stage 3: shift the largest magnitude into [2^29, 2^30)
    logic vld3_reg;
    cp_t  cp3_reg;
    cp_t  cp3_next;
    logic [MW-1:0] sh [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pos2_reg >= NORM_POS)
                sh[i] = mag2_reg[i] >> (pos2_reg - NORM_POS);
            else
                sh[i] = mag2_reg[i] << (NORM_POS - pos2_reg);
            cp3_next.nm[i] = sh[i][NMW-1:0];
        end
        cp3_next.sgn  = sgn2_reg;
        cp3_next.zero = zero2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld3_reg <= 1'b0;
        else if (en)
            vld3_reg <= vld2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cp3_reg <= cp3_next;
    end

    // Stage 4: squares
    logic             vld4_reg;
    cp_t              cp4_reg;
    logic [2*NMW-1:0] sq4_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld4_reg <= 1'b0;
        else if (en)
            vld4_reg <= vld3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cp4_reg <= cp3_reg;
            for (int i = 0; i < 3; i++)
                sq4_reg[i] <= cp3_reg.nm[i] * cp3_reg.nm[i];
        end
    end

    // Stage 5: sum of squares
    logic          vld5_reg;
    cp_t           cp5_reg;
    logic [SW-1:0] sum5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld5_reg <= 1'b0;
        else if (en)
            vld5_reg <= vld4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cp5_reg  <= cp4_reg;
            sum5_reg <= SW'(sq4_reg[0]) + SW'(sq4_reg[1]) + SW'(sq4_reg[2]);
        end
    end

    // Square root: two radicand bits per stage
    sq_t               sq_reg  [SQ_STEPS];
    cp_t               cpq_reg [SQ_STEPS];
    logic [SQ_STEPS-1:0] vq_reg;

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        sq_t           sq_in;
        sq_t           sq_next;
        cp_t           cp_in;
        logic          v_in;
        logic [RW-1:0] cur;
        logic [RW-1:0] trial;

        if (k == 0)
        begin : g_first
            assign sq_in = {sum5_reg, RW'(0), LW'(0)};
            assign cp_in = cp5_reg;
            assign v_in  = vld5_reg;
        end
        else
        begin : g_rest
            assign sq_in = sq_reg[k-1];
            assign cp_in = cpq_reg[k-1];
            assign v_in  = vq_reg[k-1];
        end

        always_comb
        begin
            cur       = {sq_in.rem[RW-3:0], sq_in.s[SW-1:SW-2]};
            trial     = RW'({sq_in.root, 2'b01});
            sq_next.s = sq_in.s << 2;
            if (cur >= trial)
            begin
                sq_next.rem  = cur - trial;
                sq_next.root = {sq_in.root[LW-2:0], 1'b1};
            end
            else
            begin
                sq_next.rem  = cur;
                sq_next.root = {sq_in.root[LW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vq_reg[k] <= 1'b0;
            else if (en)
                vq_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[k]  <= sq_next;
                cpq_reg[k] <= cp_in;
            end
        end
    end

    // Division setup: numerators with half the length added
    logic vldd_reg;
    dv_t  dv0_reg;
    dv_t  dv0_next;

    always_comb
    begin
        dv0_next.len = sq_reg[SQ_STEPS-1].root;
        for (int i = 0; i < 3; i++)
        begin
            dv0_next.rem[i] = DW'({cpq_reg[SQ_STEPS-1].nm[i], UNIT_FRAC'(0)})
                              + DW'(dv0_next.len >> 1);
            dv0_next.q[i]   = '0;
        end
        dv0_next.sgn  = cpq_reg[SQ_STEPS-1].sgn;
        dv0_next.zero = cpq_reg[SQ_STEPS-1].zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vldd_reg <= 1'b0;
        else if (en)
            vldd_reg <= vq_reg[SQ_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dv0_reg <= dv0_next;
    end

    // Restoring division: one quotient bit per stage
    dv_t                  dv_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] vdv_reg;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        dv_t           dv_in;
        dv_t           dv_next;
        logic          v_in;
        logic [DW-1:0] dvsr;

        if (k == 0)
        begin : g_first
            assign dv_in = dv0_reg;
            assign v_in  = vldd_reg;
        end
        else
        begin : g_rest
            assign dv_in = dv_reg[k-1];
            assign v_in  = vdv_reg[k-1];
        end

        always_comb
        begin
            dvsr    = DW'(dv_in.len) << (QW - 1 - k);
            dv_next = dv_in;
            for (int i = 0; i < 3; i++)
            begin
                if (dv_in.rem[i] >= dvsr)
                begin
                    dv_next.rem[i] = dv_in.rem[i] - dvsr;
                    dv_next.q[i]   = {dv_in.q[i][QW-2:0], 1'b1};
                end
                else
                begin
                    dv_next.q[i]   = {dv_in.q[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vdv_reg[k] <= 1'b0;
            else if (en)
                vdv_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dv_reg[k] <= dv_next;
        end
    end

    // Final stage: apply signs, drop zero-length vectors
    logic  vldo_reg;
    logic  zero_reg;
    unit_t u_reg [3];
    unit_t mq    [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mq[i] = $signed({1'b0, dv_reg[DIV_STEPS-1].q[i]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vldo_reg <= 1'b0;
        else if (en)
            vldo_reg <= vdv_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg <= dv_reg[DIV_STEPS-1].zero;
            for (int i = 0; i < 3; i++)
            begin
                if (dv_reg[DIV_STEPS-1].zero)
                    u_reg[i] <= '0;
                else if (dv_reg[DIV_STEPS-1].sgn[i])
                    u_reg[i] <= -mq[i];
                else
                    u_reg[i] <= mq[i];
            end
        end
    end

    assign vld_out  = vldo_reg;
    assign zero_out = zero_reg;
    assign uout     = u_reg;

endmodule

@@ tb/sv/tb_pkg_note.sv @@
`timescale 1ns / 1ps
// Shared view record used by the checker in tb_top.
package tb_view_pkg;
    import lavm_pkg::*;

    typedef struct packed {
        unit_t  side_x, side_y, side_z;
        unit_t  vert_x, vert_y, vert_z;
        unit_t  back_x, back_y, back_z;
        coord_t shift_x, shift_y, shift_z;
    } view_rec_t;

    typedef struct packed {
        coord_t eye_x, eye_y, eye_z;
        coord_t target_x, target_y, target_z;
        coord_t upref_x, upref_y, upref_z;
    } cam_rec_t;
endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import lavm_pkg::*;
    import tb_view_pkg::*;

    localparam int LATENCY = 2 * 55 + 7;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    bit   failed;
    bit   sender_busy;
    bit   quiet_phase;
    int   idle_cycles;

    view_rec_t view_expected_q[$];

    lavm_cam_if  cam ();
    lavm_view_if view ();

    look_at_view_matrix_core u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .cam  (cam.sink),
        .view (view.source)
    );

    // Generate clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hold reset low at start, then release it
    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic longint magnitude(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0)
        begin
            if (s >= root + b)
            begin
                s = s - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint round_q16(input longint x);
        longint unsigned m;
        longint unsigned r;
        m = magnitude(x);
        r = (m + (64'd1 << 15)) >> 16;
        return x < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // Scale magnitudes into [2^29, 2^30), then divide by the integer length
    function automatic bit unit_vector(input longint v[3], output longint u[3]);
        longint unsigned m[3];
        longint unsigned big;
        longint unsigned s;
        longint unsigned len;
        longint unsigned q;
        big = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = magnitude(v[i]);
            if (m[i] > big) big = m[i];
        end
        if (big == 0) return 1'b0;
        while (big >= (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            big = big >> 1;
        end
        while (big < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            big = big << 1;
        end
        for (int i = 0; i < 3; i++) s += m[i] * m[i];
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << 16) + (len >> 1)) / len;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3], output longint c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic longint translation(input longint a[3], input longint e[3]);
        return round_q16(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
    endfunction

    // Build the expected view matrix for one camera
    function automatic view_rec_t build_view(input cam_rec_t c);
        longint eye[3], tgt[3], upr[3], d[3], f[3], cr[3], r[3], raw[3], u[3], t[3];
        view_rec_t v;
        v = '0;
        eye = '{longint'(c.eye_x), longint'(c.eye_y), longint'(c.eye_z)};
        tgt = '{longint'(c.target_x), longint'(c.target_y), longint'(c.target_z)};
        upr = '{longint'(c.upref_x), longint'(c.upref_y), longint'(c.upref_z)};
        for (int i = 0; i < 3; i++) d[i] = tgt[i] - eye[i];
        if (!unit_vector(d, f)) return v;
        cross3(f, upr, cr);
        if (!unit_vector(cr, r)) return v;
        cross3(r, f, raw);
        for (int i = 0; i < 3; i++) u[i] = clip(round_q16(raw[i]), -65536, 65536);
        t[0] = clip(-translation(r, eye), -64'sd2147483648, 64'sd2147483647);
        t[1] = clip(-translation(u, eye), -64'sd2147483648, 64'sd2147483647);
        t[2] = clip(translation(f, eye), -64'sd2147483648, 64'sd2147483647);
        v.side_x = unit_t'(r[0]); v.side_y = unit_t'(r[1]); v.side_z = unit_t'(r[2]);
        v.vert_x = unit_t'(u[0]); v.vert_y = unit_t'(u[1]); v.vert_z = unit_t'(u[2]);
        v.back_x = unit_t'(-f[0]); v.back_y = unit_t'(-f[1]); v.back_z = unit_t'(-f[2]);
        v.shift_x = coord_t'(t[0]); v.shift_y = coord_t'(t[1]); v.shift_z = coord_t'(t[2]);
        return v;
    endfunction

    function automatic bit take_gap();
        return !quiet_phase && ($urandom_range(99) < 14);
    endfunction

    // Compare one field and flag a mismatch
    function automatic void check_field(input string name, input logic signed [63:0] exp_f,
                                        input logic signed [63:0] got_f);
        if (got_f !== exp_f)
        begin
            $error("%s exp %0d got %0d", name, exp_f, got_f);
            failed = 1'b1;
        end
    endfunction

    // Drive inputs to known values
    initial
    begin
        cam.valid = 1'b0;
        {cam.eye_x, cam.eye_y, cam.eye_z} = '0;
        {cam.target_x, cam.target_y, cam.target_z} = '0;
        {cam.upref_x, cam.upref_y, cam.upref_z} = '0;
        view.ready = 1'b0;
    end

    // Stall the output at random
    always @(posedge clk)
        if (rst_n) view.ready <= !take_gap();

    // Check each view transfer against the oldest expectation
    always @(posedge clk)
    begin
        view_rec_t got;
        view_rec_t exp_v;
        if (rst_n && view.valid && view.ready)
        begin
            got = '{view.side_x, view.side_y, view.side_z, view.vert_x, view.vert_y,
                    view.vert_z, view.back_x, view.back_y, view.back_z,
                    view.shift_x, view.shift_y, view.shift_z};
            if (view_expected_q.size() == 0)
            begin
                $error("view transfer with nothing expected");
                failed = 1'b1;
            end
            else
            begin
                exp_v = view_expected_q.pop_front();
                check_field("side_x", exp_v.side_x, got.side_x);
                check_field("side_y", exp_v.side_y, got.side_y);
                check_field("side_z", exp_v.side_z, got.side_z);
                check_field("vert_x", exp_v.vert_x, got.vert_x);
                check_field("vert_y", exp_v.vert_y, got.vert_y);
                check_field("vert_z", exp_v.vert_z, got.vert_z);
                check_field("back_x", exp_v.back_x, got.back_x);
                check_field("back_y", exp_v.back_y, got.back_y);
                check_field("back_z", exp_v.back_z, got.back_z);
                check_field("shift_x", exp_v.shift_x, got.shift_x);
                check_field("shift_y", exp_v.shift_y, got.shift_y);
                check_field("shift_z", exp_v.shift_z, got.shift_z);
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((cam.valid && cam.ready) || (view.valid && view.ready) ||
            (!sender_busy && view_expected_q.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** look_at_view_matrix_core: FAILED **");
            $finish;
        end
    end

    // Send one camera; random gap first, then hold until taken
    task automatic send_camera(input cam_rec_t c);
        while (take_gap())
        begin
            cam.valid <= 1'b0;
            @(posedge clk);
        end
        cam.valid <= 1'b1;
        {cam.eye_x, cam.eye_y, cam.eye_z} <= {c.eye_x, c.eye_y, c.eye_z};
        {cam.target_x, cam.target_y, cam.target_z} <= {c.target_x, c.target_y, c.target_z};
        {cam.upref_x, cam.upref_y, cam.upref_z} <= {c.upref_x, c.upref_y, c.upref_z};
        @(posedge clk);
        while (!cam.ready) @(posedge clk);
        view_expected_q.push_back(build_view(c));
    endtask

    task automatic release_cam();
        cam.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(4))
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(65536 * 8)) - 65536 * 4);
            2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return coord_t'($signed($urandom_range(32'h00FFFFFF)) - 32'sh00800000);
        endcase
    endfunction

    function automatic cam_rec_t make_cam(input coord_t ex, ey, ez, tx, ty, tz,
                                          ux, uy, uz);
        cam_rec_t c;
        c = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
        return c;
    endfunction

    // Extremes, identity camera and both degenerate cases
    task automatic test_directed();
        localparam coord_t ONE = 32'sh00010000;
        localparam coord_t MAXC = 32'sh7FFFFFFF;
        localparam coord_t MINC = 32'sh80000000;
        send_camera(make_cam(0, 0, ONE * 5, 0, 0, 0, 0, ONE, 0));
        send_camera(make_cam(ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0));
        send_camera(make_cam(0, 0, 0, 0, ONE, 0, 0, ONE, 0));
        send_camera(make_cam(0, 0, 0, ONE, 0, 0, 0, 0, 0));
        send_camera(make_cam(MINC, MINC, MINC, MAXC, MAXC, MAXC, 0, ONE, 0));
        send_camera(make_cam(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC));
        send_camera(make_cam(MAXC, MINC, 0, MINC, MAXC, 1, MINC, MINC, MINC));
        send_camera(make_cam(MINC, 0, MAXC, 0, 0, 0, -1, 1, -1));
        send_camera(make_cam(MAXC, MAXC, MINC, MAXC, MAXC, MAXC, 1, 0, 0));
        send_camera(make_cam(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_camera(make_cam(0, 0, 0, 3, 4, 0, 0, 0, MAXC));
        send_camera(make_cam(-1, -1, -1, 32'shFFFFFFFF, -1, -1, 1, 1, 1));
        send_camera(make_cam(ONE, 0, 0, ONE * 2, 0, 0, ONE * 7, 0, 0));
        send_camera(make_cam(32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F,
                             32'shAAAAAAAA, 32'sh55555555, 32'shF0F0F0F0,
                             32'sh33333333, 32'shCCCCCCCC, 32'sh12345678));
        release_cam();
    endtask

    // Random cameras; some with the eye on the target or up along forward
    task automatic test_random(input int count);
        cam_rec_t c;
        coord_t k;
        for (int n = 0; n < count; n++)
        begin
            quiet_phase = (n >= count / 3) && (n < count / 2);
            c = make_cam(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord());
            case ($urandom_range(19))
                0: {c.target_x, c.target_y, c.target_z} = {c.eye_x, c.eye_y, c.eye_z};
                1:
                begin
                    k = coord_t'($urandom_range(7));
                    c.target_x = c.eye_x + k;
                    c.target_y = c.eye_y;
                    c.target_z = c.eye_z;
                    c.upref_x = coord_t'($urandom);
                    c.upref_y = 0;
                    c.upref_z = 0;
                end
                default: ;
            endcase
            send_camera(c);
        end
        quiet_phase = 1'b0;
        release_cam();
    endtask

    // Hold off until every expected view has arrived
    task automatic test_drain();
        while (view_expected_q.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        failed = 1'b0;
        quiet_phase = 1'b0;
        idle_cycles = 0;
        sender_busy = 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        test_directed();
        test_drain();
        test_random(1000);
        sender_busy = 1'b0;
        test_drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (!failed && view_expected_q.size() == 0)
            $display("** look_at_view_matrix_core: PASSED **");
        else
            $display("** look_at_view_matrix_core: FAILED **");
        $finish;
    end
endmodule
